FILE: rtl/dcpt_pkg.sv
// shared constants for the divisor count prime test block
package dcpt_pkg;
	localparam int unsigned VALUE_BITS_DEF = 20;
	localparam int unsigned COUNT_BITS = 10;
	localparam int unsigned TOTAL_BITS = 20;
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;
endpackage

FILE: rtl/divisor_count_prime_test.sv
// top level of the divisor count prime test block
// Each value is factored by trial division on one shared iterative divider,
// trying each candidate divisor up to sqrt(value) and dividing again by it
// while it goes, then a short trial-division primality test of the count is
// run on the same divider. A two-entry queue takes items while the engine
// works and one output register holds the finished result.
module divisor_count_prime_test #(
	parameter int unsigned VALUE_BITS = dcpt_pkg::VALUE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [19:0] value,
	input  logic        last,
	output logic        empty,
	input  logic        pop,
	output logic [dcpt_pkg::COUNT_BITS-1:0] divisor_count,
	output logic        count_is_prime,
	output logic [dcpt_pkg::TOTAL_BITS-1:0] prime_total,
	output logic        run_end
);
	import dcpt_pkg::*;

	logic                  q_valid, q_take, q_last;
	logic [VALUE_BITS-1:0] q_value;

	// input side
	dcpt_front #(.VALUE_BITS(VALUE_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.value(value), .last(last), .q_valid(q_valid), .q_take(q_take),
		.q_value(q_value), .q_last(q_last)
	);

	// factoring engine
	dcpt_back #(.VALUE_BITS(VALUE_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_take(q_take),
		.q_value(q_value), .q_last(q_last), .empty(empty), .pop(pop),
		.divisor_count(divisor_count), .count_is_prime(count_is_prime),
		.prime_total(prime_total), .run_end(run_end)
	);
endmodule

FILE: rtl/dcpt_front.sv
// front end: captures items and queues them for the factoring engine
module dcpt_front #(
	parameter int unsigned VALUE_BITS = dcpt_pkg::VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic [19:0]           value,
	input  logic                  last,
	output logic                  q_valid,
	input  logic                  q_take,
	output logic [VALUE_BITS-1:0] q_value,
	output logic                  q_last
);
	import dcpt_pkg::*;

	logic [VALUE_BITS-1:0] val_q [QUEUE_DEPTH];
	logic                  last_q [QUEUE_DEPTH];
	logic                  wr_q, rd_q;
	logic [1:0]            cnt_q;
	logic                  do_push, do_pop;
	logic [VALUE_BITS-1:0] val_in;

	// value masked to the configured width
	always_comb begin
		val_in = '0;
		for (int i = 0; i < VALUE_BITS; i++) begin
			if (i < 20) val_in[i] = value[i];
		end
	end

	assign full    = (cnt_q == 2'(QUEUE_DEPTH));
	assign q_valid = (cnt_q != 2'd0);
	assign do_push = push && !full;
	assign do_pop  = q_take && q_valid;
	assign q_value = val_q[rd_q];
	assign q_last  = last_q[rd_q];

	// two-entry queue storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			val_q[wr_q]  <= val_in;
			last_q[wr_q] <= last;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wr_q <= ~wr_q;
			if (do_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end
endmodule

FILE: rtl/dcpt_div.sv
// iterative restoring divider giving the remainder and quotient
module dcpt_div #(
	parameter int unsigned W = 20
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quot,
	output logic [W-1:0] rem
);
	localparam int unsigned CW = $clog2(W + 1);

	logic [W-1:0]  quot_q, rem_q, dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [W:0]    trial;

	assign trial = {rem_q, quot_q[W-1]} - {1'b0, dvs_q};
	assign quot  = quot_q;
	assign rem   = rem_q;
	assign done  = busy_q && (cnt_q == CW'(0));

	// one quotient bit a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(W);
		end else if (busy_q && cnt_q != CW'(0)) begin
			cnt_q <= cnt_q - CW'(1);
		end else begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
			dvs_q  <= divisor;
		end else if (busy_q && cnt_q != CW'(0)) begin
			if (!trial[W]) begin
				rem_q  <= trial[W-1:0];
				quot_q <= {quot_q[W-2:0], 1'b1};
			end else begin
				rem_q  <= {rem_q[W-2:0], quot_q[W-1]};
				quot_q <= {quot_q[W-2:0], 1'b0};
			end
		end
	end
endmodule

FILE: rtl/dcpt_back.sv
// back end: trial division, primality test of the count and run total
module dcpt_back #(
	parameter int unsigned VALUE_BITS = dcpt_pkg::VALUE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_valid,
	output logic                           q_take,
	input  logic [VALUE_BITS-1:0]          q_value,
	input  logic                           q_last,
	output logic                           empty,
	input  logic                           pop,
	output logic [dcpt_pkg::COUNT_BITS-1:0] divisor_count,
	output logic                           count_is_prime,
	output logic [dcpt_pkg::TOTAL_BITS-1:0] prime_total,
	output logic                           run_end
);
	import dcpt_pkg::*;

	// counts stay below 2^(VALUE_BITS); the datapath keeps one bit of headroom
	localparam int unsigned KW = VALUE_BITS + 1;
	localparam int unsigned DW = (KW > VALUE_BITS) ? KW : VALUE_BITS;

	typedef enum logic [3:0] {
		S_IDLE, S_CHK, S_DIVW, S_NEXT, S_MUL, S_PCHK, S_PDIVW, S_DONE, S_HOLD
	} state_t;

	state_t        state_q;
	logic [DW-1:0] n_q, d_q, e_q, cnt_q;
	logic          last_q;
	logic          prime_q;
	logic [TOTAL_BITS-1:0] total_q;
	logic          out_valid_q;
	logic [COUNT_BITS-1:0] o_count_q;
	logic          o_prime_q, o_end_q;
	logic [TOTAL_BITS-1:0] o_total_q;

	logic          div_start;
	logic [DW-1:0] div_a, div_b, div_quot, div_rem;
	logic          div_done;
	logic [2*DW-1:0] dsq;
	logic          out_free;
	logic          out_load;

	assign out_free = !out_valid_q || pop;
	assign out_load = (state_q == S_DONE) && out_free;
	assign dsq      = d_q * d_q;
	assign q_take   = (state_q == S_IDLE) && q_valid;

	dcpt_div #(.W(DW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(div_a), .divisor(div_b), .done(div_done),
		.quot(div_quot), .rem(div_rem)
	);

	// divider operands depend on phase
	always_comb begin
		div_start = 1'b0;
		div_a     = n_q;
		div_b     = d_q;
		if (state_q == S_CHK && dsq <= {{DW{1'b0}}, n_q}) div_start = 1'b1;
		if (state_q == S_NEXT) div_start = 1'b1;
		if (state_q == S_PCHK) begin
			div_a = cnt_q;
			if (dsq <= {{DW{1'b0}}, cnt_q}) div_start = 1'b1;
		end
	end

	// sequencer for factoring and primality test
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			total_q     <= '0;
			out_valid_q <= 1'b0;
			n_q <= '0; d_q <= '0; e_q <= '0; cnt_q <= '0;
			last_q <= 1'b0; prime_q <= 1'b0;
			o_count_q <= '0; o_prime_q <= 1'b0; o_end_q <= 1'b0; o_total_q <= '0;
		end else begin
			if (out_load) out_valid_q <= 1'b1;
			else if (pop) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						n_q     <= DW'(q_value);
						last_q  <= q_last;
						d_q     <= DW'(2);
						e_q     <= DW'(1);
						cnt_q   <= DW'(1);
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (dsq <= {{DW{1'b0}}, n_q}) begin
						state_q <= S_DIVW;
					end else begin
						if (n_q > DW'(1)) cnt_q <= cnt_q << 1;
						d_q     <= DW'(2);
						state_q <= S_PCHK;
					end
				end
				S_DIVW: begin
					if (div_done) begin
						if (div_rem == '0) begin
							n_q     <= div_quot;
							e_q     <= e_q + DW'(1);
							state_q <= S_NEXT;
						end else begin
							state_q <= S_MUL;
						end
					end
				end
				S_MUL: begin
					cnt_q   <= DW'(cnt_q * e_q);
					e_q     <= DW'(1);
					d_q     <= d_q + DW'(1);
					state_q <= S_CHK;
				end
				S_NEXT: begin
					// divide again by the same candidate until it no longer goes
					state_q <= S_DIVW;
				end
				S_PCHK: begin
					if (dsq <= {{DW{1'b0}}, cnt_q}) begin
						state_q <= S_PDIVW;
					end else begin
						prime_q <= (cnt_q >= DW'(2));
						state_q <= S_DONE;
					end
				end
				S_PDIVW: begin
					if (div_done) begin
						if (div_rem == '0) begin
							prime_q <= 1'b0;
							state_q <= S_DONE;
						end else begin
							d_q     <= d_q + DW'(1);
							state_q <= S_PCHK;
						end
					end
				end
				S_DONE: begin
					if (out_free) begin
						o_count_q   <= cnt_q[COUNT_BITS-1:0];
						o_prime_q   <= prime_q;
						o_end_q     <= last_q;
						if (prime_q && total_q != TOTAL_MAX) begin
							o_total_q <= total_q + TOTAL_BITS'(1);
							total_q   <= last_q ? '0 : total_q + TOTAL_BITS'(1);
						end else begin
							o_total_q <= total_q;
							total_q   <= last_q ? '0 : total_q;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign empty          = !out_valid_q;
	assign divisor_count  = o_count_q;
	assign count_is_prime = o_prime_q;
	assign prime_total    = o_total_q;
	assign run_end        = o_end_q;
endmodule

FILE: rtl/dcpt_checker.sv
// port-level checks for the divisor count prime test block
module dcpt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [9:0]  divisor_count,
	input logic        count_is_prime,
	input logic [19:0] prime_total
);
	// a held result stays put (the divisor count is checked)
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> !empty && $stable(divisor_count))
		else $error("result changed while held");

	// count one is never prime
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && divisor_count == 10'd1) |-> !count_is_prime)
		else $error("count one marked prime");

	// a prime count is odd unless it is two
	a_even: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && count_is_prime && !divisor_count[0]) |-> divisor_count == 10'd2)
		else $error("even count marked prime");

	// total is never zero for a prime item
	a_tot: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && count_is_prime) |-> prime_total != 20'd0)
		else $error("prime item with zero total");
endmodule

bind divisor_count_prime_test dcpt_checker u_chk (
	.clk(clk), .arst_n(arst_n), .empty(empty), .pop(pop),
	.divisor_count(divisor_count), .count_is_prime(count_is_prime),
	.prime_total(prime_total)
);

FILE: tb/divisor_count_prime_test_tb.sv
// self-checking testbench for the divisor count prime test block
`timescale 1ns / 100ps

module divisor_count_prime_test_tb;
	import dcpt_pkg::*;

	typedef struct {
		logic [19:0] value;
		logic        last;
		bit          drain;
		int          phase;
	} value_txn_t;

	typedef struct {
		logic [COUNT_BITS-1:0] divisor_count;
		logic                  count_is_prime;
		logic [TOTAL_BITS-1:0] prime_total;
		logic                  run_end;
	} count_txn_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic [19:0] value = '0;
	logic last = 1'b0;
	logic empty;
	logic pop = 1'b0;
	logic [COUNT_BITS-1:0] divisor_count;
	logic count_is_prime;
	logic [TOTAL_BITS-1:0] prime_total;
	logic run_end;

	value_txn_t pending_values[$];
	count_txn_t expected_counts[$];
	logic [TOTAL_BITS-1:0] model_total = '0;
	int phase = 0;
	bit accepted = 1'b0;
	int mismatches = 0;
	int checked = 0;
	int prime_seen = 0;
	int runs_seen = 0;

	divisor_count_prime_test DUT (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .value(value),
		.last(last), .empty(empty), .pop(pop), .divisor_count(divisor_count),
		.count_is_prime(count_is_prime), .prime_total(prime_total), .run_end(run_end)
	);

	// clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// number of divisors by trial division
	function automatic int unsigned divisors_of(logic [19:0] v);
		longint unsigned n;
		longint unsigned d;
		int unsigned cnt;
		int unsigned e;
		n = v;
		cnt = 1;
		for (d = 2; d * d <= n; d++) begin
			e = 1;
			while (n % d == 0) begin
				e++;
				n = n / d;
			end
			cnt = cnt * e;
		end
		if (n > 1)
			cnt = cnt * 2;
		return cnt;
	endfunction

	function automatic bit is_prime_count(int unsigned k);
		int unsigned d;
		if (k < 2)
			return 1'b0;
		for (d = 2; d * d <= k; d++)
			if (k % d == 0)
				return 1'b0;
		return 1'b1;
	endfunction

	// expected result of one accepted value, updating the running total
	function automatic count_txn_t predict_count(logic [19:0] v, logic lst);
		count_txn_t r;
		int unsigned cnt;
		bit pr;
		cnt = divisors_of(v);
		pr = is_prime_count(cnt);
		if (pr && model_total != TOTAL_MAX)
			model_total = model_total + 1'b1;
		r.divisor_count = cnt[COUNT_BITS-1:0];
		r.count_is_prime = pr;
		r.prime_total = model_total;
		r.run_end = lst;
		if (lst)
			model_total = '0;
		return r;
	endfunction

	function automatic int sender_idle_pct(int ph);
		return (ph == 0) ? 21 : (ph == 1) ? 56 : 0;
	endfunction

	function automatic int receiver_idle_pct(int ph);
		return (ph == 0) ? 56 : (ph == 1) ? 21 : 0;
	endfunction

	// input transaction accepted: predict it
	always @(posedge clk) begin
		accepted <= 1'b0;
		if (arst_n && push && !full) begin
			expected_counts.push_back(predict_count(value, last));
			accepted <= 1'b1;
		end
	end

	// driver
	always @(negedge clk) begin
		if (arst_n && (!push || accepted)) begin
			if (pending_values.size() > 0
					&& (!pending_values[0].drain || expected_counts.size() == 0)
					&& $urandom_range(99) >= sender_idle_pct(pending_values[0].phase)) begin
				push <= 1'b1;
				value <= pending_values[0].value;
				last <= pending_values[0].last;
				phase <= pending_values[0].phase;
				void'(pending_values.pop_front());
			end else begin
				push <= 1'b0;
				value <= 20'($urandom_range(20'hFFFFF));
				last <= 1'($urandom_range(1));
			end
		end
	end

	// receiver stalls
	always @(negedge clk) begin
		if (arst_n)
			pop <= ($urandom_range(99) >= receiver_idle_pct(phase));
	end

	// monitor: compare each result transaction with the oldest expectation
	always @(posedge clk) begin
		count_txn_t exp_r;
		if (arst_n && pop && !empty) begin
			if (expected_counts.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: count=%0d prime=%0b total=%0d end=%0b",
						divisor_count, count_is_prime, prime_total, run_end);
			end else begin
				exp_r = expected_counts.pop_front();
				checked++;
				if (run_end)
					runs_seen++;
				if (count_is_prime)
					prime_seen++;
				if (divisor_count !== exp_r.divisor_count
						|| count_is_prime !== exp_r.count_is_prime
						|| prime_total !== exp_r.prime_total
						|| run_end !== exp_r.run_end) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch at result %0d: exp %0d/%0b/%0d/%0b got %0d/%0b/%0d/%0b",
							checked, exp_r.divisor_count, exp_r.count_is_prime,
							exp_r.prime_total, exp_r.run_end, divisor_count,
							count_is_prime, prime_total, run_end);
				end
			end
		end
	end

	task automatic add_value(logic [19:0] v, logic lst, bit drain, int ph);
		value_txn_t t;
		t.value = v;
		t.last = lst;
		t.drain = drain;
		t.phase = ph;
		pending_values.push_back(t);
	endtask

	// stimulus and end of run
	initial begin
		logic [19:0] v;
		// directed: zero, one, a small prime, prime powers, extremes of the field
		add_value(20'd0, 1'b0, 1'b0, 0);
		add_value(20'd1, 1'b0, 1'b0, 0);
		add_value(20'd2, 1'b0, 1'b0, 0);
		add_value(20'd4, 1'b0, 1'b0, 0);
		add_value(20'd16, 1'b0, 1'b0, 0);
		add_value(20'd64, 1'b1, 1'b0, 0);
		add_value(20'd6, 1'b1, 1'b0, 0);
		add_value(20'd9, 1'b0, 1'b0, 0);
		add_value(20'd12, 1'b0, 1'b0, 0);
		add_value(20'hFFFFF, 1'b0, 1'b0, 0);
		add_value(20'd1048573, 1'b0, 1'b0, 0);
		add_value(20'd524288, 1'b0, 1'b0, 0);
		add_value(20'd720720, 1'b0, 1'b0, 0);
		add_value(20'd1046529, 1'b0, 1'b0, 0);
		add_value(20'h55555, 1'b0, 1'b0, 0);
		add_value(20'hAAAAA, 1'b1, 1'b0, 0);
		add_value(20'd729, 1'b1, 1'b0, 0);
		// random: mostly small values, a few across the full range
		for (int i = 0; i < 272; i++) begin
			if ($urandom_range(19) == 0)
				v = 20'($urandom_range(20'hFFFFF));
			else
				v = 20'($urandom_range(1023));
			add_value(v, ($urandom_range(11) == 0), (i == 150), i * 3 / 272);
		end
		add_value(20'd3, 1'b1, 1'b0, 2);

		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		wait (pending_values.size() == 0 && !push);
		wait (expected_counts.size() == 0);
		repeat (200) @(posedge clk);
		$display("checked %0d results over %0d runs, %0d with a prime divisor count",
			checked, runs_seen, prime_seen);
		if (mismatches == 0 && expected_counts.size() == 0)
			$display("PASS divisor_count_prime_test");
		else
			$display("FAIL divisor_count_prime_test");
		$finish;
	end

	// watchdog
	initial begin
		#100_000_000;
		$display("FAIL divisor_count_prime_test");
		$finish;
	end

endmodule
